### src/occupancy_grid_ray_update_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the occupancy grid ray update block
// Shared property forms; the asserting module provides clk and rst.
// ---------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OGRU_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define OGRU_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

### src/ogru_pkg.sv
// ---------------------------------------------------------------------------
// Occupancy grid ray update package
// Grid geometry, cell and mode codes, register indexes and payload types.
// ---------------------------------------------------------------------------
package ogru_pkg;

  localparam int GRID_COLS = 256;
  localparam int GRID_ROWS = 256;
  localparam int COL_W     = $clog2(GRID_COLS);
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int ADDR_W    = COL_W + ROW_W;
  localparam int MAP_DEPTH = GRID_COLS * GRID_ROWS;
  // Signed walk coordinate: holds the origin range and one cell past each edge.
  localparam int MAXI_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int POS_W     = ((MAXI_W > 8) ? MAXI_W : 8) + 2;
  localparam int STEP_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [1:0] CELL_UNKNOWN = 2'd0;
  localparam logic [1:0] CELL_FREE    = 2'd1;
  localparam logic [1:0] CELL_OCC     = 2'd2;

  localparam logic [1:0] MODE_MARK  = 2'd0;
  localparam logic [1:0] MODE_TRACE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_X_MAX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_C  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_R  = 3'd6;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } ogru_in_t;

  typedef struct packed {
    logic [1:0] cell_state;
    logic       ignored;
    logic       off_map;
    logic [8:0] cells_freed;
  } ogru_out_t;

endpackage

### src/ogru_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ogru_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ogru_div.sv
// ---------------------------------------------------------------------------
// Dual restoring divider
// Divides two 16-bit magnitudes by one cell size, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module ogru_div import ogru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend_x,
  input  logic [15:0] dividend_y,
  input  logic [11:0] divisor,
  output logic        done,
  output logic [15:0] quot_x,
  output logic [15:0] quot_y
);

  logic        busy;
  logic [4:0]  cnt;
  logic [11:0] dvs;
  logic [11:0] rem_x, rem_y;
  logic [12:0] trial_x, trial_y;
  logic        ge_x, ge_y;

  assign trial_x = {rem_x, quot_x[15]};
  assign trial_y = {rem_y, quot_y[15]};
  assign ge_x    = trial_x >= {1'b0, dvs};
  assign ge_y    = trial_y >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        dvs    <= divisor;
        rem_x  <= '0;
        rem_y  <= '0;
        quot_x <= dividend_x;
        quot_y <= dividend_y;
      end else if (busy) begin
        // The remainder stays below the divisor, so 12 bits hold it.
        rem_x  <= ge_x ? 12'(trial_x - {1'b0, dvs}) : trial_x[11:0];
        rem_y  <= ge_y ? 12'(trial_y - {1'b0, dvs}) : trial_y[11:0];
        quot_x <= {quot_x[14:0], ge_x};
        quot_y <= {quot_y[14:0], ge_y};
        cnt    <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/occupancy_grid_ray_update.sv
// ---------------------------------------------------------------------------
// Occupancy grid ray update
// Two-bit occupancy map updated by lidar points: mark, trace and read.
// ---------------------------------------------------------------------------
// After reset the block sweeps the map to unknown, one cell a cycle, and
// takes no request until the sweep ends. A mark waits on the divider that
// turns millimetres into cells. A trace takes the same set-up and then, for
// each cell walked, a read of the map, a write-back with the multiplies of
// the side test, a sum and the corner decision. A trace walks at most the
// column plus row offset of its point. One request is in work at a time; a
// finished result waits in the output register.
// ---------------------------------------------------------------------------
`include "occupancy_grid_ray_update_defines.svh"

module occupancy_grid_ray_update import ogru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ogru_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ogru_out_t            out_data
);

  localparam int MK_W = 19;
  localparam int RW   = POS_W + 14;
  localparam int DW   = POS_W + 32;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_RDATA, S_DIV, S_MARK, S_PQ,
    S_WCHK, S_WMUL, S_WSUM, S_WSIDE, S_DONE
  } state_t;

  state_t state;

  logic signed [15:0] x_max, x_min, y_max, y_min;
  logic [11:0]        cell_size;
  logic [7:0]         origin_col, origin_row;

  ogru_in_t    item;
  logic [11:0] csz;
  logic [1:0]  r_state;
  logic        r_ign, r_off;
  logic [8:0]  r_freed;

  logic [ADDR_W-1:0] clr_addr;

  // Divider
  logic        div_start, div_done;
  logic [15:0] nx, ny;
  logic [15:0] abs_x, abs_y;
  logic        in_scope;

  // Walk
  logic signed [POS_W-1:0]  col, row;
  logic [STEP_W-1:0]        steps, j;
  logic signed [RW-1:0]     rxm, rym;
  logic signed [DW-1:0]     pa, pb, pp, pq, d0;
  logic signed [POS_W:0]    dx, dy;
  logic signed [13:0]       cs_s;
  logic                     walk_on_map;
  logic signed [DW-1:0]     d_b, d_e, d_f;
  logic                     up_a, up_b, up_e, up_f, crossed;

  // Mark
  logic signed [MK_W-1:0]   oc_w, or_w, nx_w, ny_w, mk_col, mk_row;
  logic                     mk_on_map;

  // Map port
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [1:0]        mem_wdata, mem_rdata;

  function automatic logic upper(input logic signed [DW-1:0] d, input logic pneg);
    return pneg ? d[DW-1] : (!d[DW-1] && (d != '0));
  endfunction

  assign in_ready = (state == S_IDLE);

  assign abs_x    = in_data.point_x[15] ? 16'(-in_data.point_x) : in_data.point_x;
  assign abs_y    = in_data.point_y[15] ? 16'(-in_data.point_y) : in_data.point_y;
  assign in_scope = (in_data.point_x < x_max) && (in_data.point_x > x_min) &&
                    (in_data.point_y < y_max) && (in_data.point_y > y_min);
  assign div_start = in_ready && in_valid && in_scope &&
                     ((in_data.mode == MODE_MARK) || (in_data.mode == MODE_TRACE));

  ogru_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .dividend_x (abs_x),
    .dividend_y (abs_y),
    .divisor    ((cell_size == 12'd0) ? 12'd1 : cell_size),
    .done       (div_done),
    .quot_x     (nx),
    .quot_y     (ny)
  );

  // Endpoint cell for a mark.
  assign oc_w   = MK_W'(origin_col);
  assign or_w   = MK_W'(origin_row);
  assign nx_w   = MK_W'(nx);
  assign ny_w   = MK_W'(ny);
  assign mk_col = item.point_x[15] ? oc_w - nx_w : oc_w + nx_w + MK_W'(1);
  assign mk_row = item.point_y[15] ? or_w + ny_w + MK_W'(1) : or_w - ny_w;
  assign mk_on_map = (mk_col >= 0) && (mk_col < GRID_COLS) &&
                     (mk_row >= 0) && (mk_row < GRID_ROWS);

  // Lower-left corner of the candidate next-column cell, in cells.
  assign cs_s = $signed({2'b00, csz});
  assign dx = (item.point_x > 0)
            ? (POS_W + 1)'(col) - (POS_W + 1)'(origin_col)
            : (POS_W + 1)'(col) - (POS_W + 1)'(origin_col) - (POS_W + 1)'(2);
  assign dy = (POS_W + 1)'(origin_row) - (POS_W + 1)'(row);
  assign walk_on_map = (col >= 0) && (col < GRID_COLS) &&
                       (row >= 0) && (row < GRID_ROWS);

  // Corner offsets follow from the first corner: +c in x subtracts py*c,
  // +c in y adds px*c.
  assign d_b     = d0 - pq;
  assign d_e     = d0 + pp;
  assign d_f     = d0 + pp - pq;
  assign up_a    = upper(d0,  item.point_x[15]);
  assign up_b    = upper(d_b, item.point_x[15]);
  assign up_e    = upper(d_e, item.point_x[15]);
  assign up_f    = upper(d_f, item.point_x[15]);
  assign crossed = !((up_a == up_b) && (up_e == up_f) && (up_a == up_e));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {ROW_W'(row), COL_W'(col)};
    mem_wdata = CELL_FREE;
    mem_raddr = {ROW_W'(row), COL_W'(col)};
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = CELL_UNKNOWN;
      end
      S_READ: begin
        mem_raddr = {ROW_W'(item.read_row), COL_W'(item.read_col)};
      end
      S_MARK: begin
        mem_we    = mk_on_map;
        mem_waddr = {ROW_W'(mk_row), COL_W'(mk_col)};
        mem_wdata = CELL_OCC;
      end
      S_WMUL: begin
        mem_we = (mem_rdata == CELL_UNKNOWN);
      end
      default: begin
      end
    endcase
  end

  ogru_ram #(.WIDTH(2), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
      x_max      <= 16'sd20000;
      x_min      <= -16'sd20000;
      y_max      <= 16'sd20000;
      y_min      <= -16'sd20000;
      cell_size  <= 12'd200;
      origin_col <= 8'd127;
      origin_row <= 8'd127;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_X_MAX: x_max      <= cfg_data;
          REG_X_MIN: x_min      <= cfg_data;
          REG_Y_MAX: y_max      <= cfg_data;
          REG_Y_MIN: y_min      <= cfg_data;
          REG_CELL:  cell_size  <= cfg_data[11:0];
          REG_ORG_C: origin_col <= cfg_data[7:0];
          REG_ORG_R: origin_row <= cfg_data[7:0];
          default: begin
          end
        endcase
      end

      // In S_DONE the output register is handled by the state itself.
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item    <= in_data;
            csz     <= (cell_size == 12'd0) ? 12'd1 : cell_size;
            r_state <= CELL_UNKNOWN;
            r_ign   <= 1'b0;
            r_off   <= 1'b0;
            r_freed <= '0;
            unique case (in_data.mode)
              MODE_READ: state <= S_READ;
              MODE_MARK, MODE_TRACE: begin
                if (in_scope) begin
                  state <= S_DIV;
                end else begin
                  r_ign <= 1'b1;
                  state <= S_DONE;
                end
              end
              MODE_NONE: state <= S_DONE;
            endcase
          end
        end
        S_READ: begin
          if ((int'(item.read_col) < GRID_COLS) && (int'(item.read_row) < GRID_ROWS)) begin
            state <= S_RDATA;
          end else begin
            r_off <= 1'b1;
            state <= S_DONE;
          end
        end
        S_RDATA: begin
          r_state <= mem_rdata;
          state   <= S_DONE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= (item.mode == MODE_MARK) ? S_MARK : S_PQ;
          end
        end
        S_MARK: begin
          r_off <= !mk_on_map;
          state <= S_DONE;
        end
        S_PQ: begin
          pp    <= DW'(item.point_x * cs_s);
          pq    <= DW'(item.point_y * cs_s);
          col   <= (item.point_x > 0) ? POS_W'(origin_col) + POS_W'(1) : POS_W'(origin_col);
          row   <= (item.point_y > 0) ? POS_W'(origin_row) : POS_W'(origin_row) + POS_W'(1);
          steps <= STEP_W'(nx) + STEP_W'(ny);
          j     <= '0;
          state <= S_WCHK;
        end
        S_WCHK: begin
          if (j == steps) begin
            state <= S_DONE;
          end else if (!walk_on_map) begin
            r_off <= 1'b1;
            state <= S_DONE;
          end else begin
            rxm   <= RW'(dx * cs_s);
            rym   <= RW'(dy * cs_s);
            state <= S_WMUL;
          end
        end
        S_WMUL: begin
          // An occupied cell ends the walk; the cell itself stays as it is.
          if (mem_rdata == CELL_OCC) begin
            state <= S_DONE;
          end else begin
            if ((mem_rdata == CELL_UNKNOWN) && (r_freed != 9'd511)) begin
              r_freed <= r_freed + 9'd1;
            end
            pa    <= DW'(item.point_x * rym);
            pb    <= DW'(item.point_y * rxm);
            state <= S_WSUM;
          end
        end
        S_WSUM: begin
          d0    <= pa - pb;
          state <= S_WSIDE;
        end
        S_WSIDE: begin
          if (crossed) begin
            col <= (item.point_x > 0) ? col + POS_W'(1) : col - POS_W'(1);
          end else begin
            row <= (item.point_y > 0) ? row - POS_W'(1) : row + POS_W'(1);
          end
          j     <= j + STEP_W'(1);
          state <= S_WCHK;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.cell_state  <= r_state;
            out_data.ignored     <= r_ign;
            out_data.off_map     <= r_off;
            out_data.cells_freed <= r_freed;
            out_valid            <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `OGRU_ASSERT_IMP(a_clear_blocks, state == S_CLEAR, !in_ready && !out_valid)
  `OGRU_ASSERT_IMP(a_walk_writes_free, mem_we && state == S_WMUL, mem_wdata == CELL_FREE)
  `OGRU_ASSERT_IMP(a_walk_bound, state == S_WCHK, j <= steps)
  `OGRU_ASSERT_IMP(a_ignored_clean, out_valid && out_data.ignored,
                   !out_data.off_map && out_data.cells_freed == 9'd0)
  `OGRU_ASSERT_NEXT(a_done_loads, state == S_DONE && !out_valid, out_valid)

endmodule

### bench/tb.sv
// ---------------------------------------------------------------------------
// Occupancy grid ray update testbench
// Drives mark, trace and read requests through the valid/ready channels with
// random idling on both sides. A predictor in the bench keeps its own copy of
// the map and the registers, and each result is checked field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ogru_pkg::*;

  localparam int CYCLE_LIMIT = 12000000;
  localparam int PHASES      = 6;
  localparam int PER_PHASE   = 190;
  localparam int IN_W        = $bits(ogru_in_t);

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  ogru_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  ogru_out_t            out_data;

  occupancy_grid_ray_update dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  // Bench copy of the block's state.
  logic [1:0]         occ_map [0:MAP_DEPTH-1] = '{default: CELL_UNKNOWN};
  logic signed [15:0] lim_x_max, lim_x_min, lim_y_max, lim_y_min;
  logic [11:0]        cell_mm;
  logic [7:0]         org_col, org_row;

  ogru_in_t  pending_requests[$];
  ogru_out_t expected_results[$];
  int        failures = 0;
  int        accepted = 0;
  int        cycles = 0;
  bit        in_fire;
  int        send_gap;
  int        recv_gap;
  int        hold_off = 0;
  bit        hold_done = 1'b0;
  bit        no_idle;
  longint    span;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic bit upper_side(longint cx, longint cy, longint px, longint py);
    longint d;
    d = px * cy - py * cx;
    return (px < 0) ? (d < 0) : (d > 0);
  endfunction

  function automatic bit ray_crosses(longint rx, longint ry, longint c,
                                     longint px, longint py);
    bit a, b, e, f;
    a = upper_side(rx, ry, px, py);
    b = upper_side(rx + c, ry, px, py);
    e = upper_side(rx, ry + c, px, py);
    f = upper_side(rx + c, ry + c, px, py);
    return !(a == b && e == f && a == e);
  endfunction

  function automatic bit in_grid(longint col, longint row);
    return col >= 0 && col < GRID_COLS && row >= 0 && row < GRID_ROWS;
  endfunction

  // Applies one request to the bench map and returns the result it causes.
  function automatic ogru_out_t update_map(ogru_in_t r);
    ogru_out_t res;
    longint px, py, c, nx, ny, sx, sy, col, row, steps, jx, rx, ry;
    res = '0;
    px = longint'($signed(r.point_x));
    py = longint'($signed(r.point_y));
    c  = (cell_mm == 0) ? 1 : longint'(cell_mm);
    if (r.mode == MODE_READ) begin
      res.cell_state = occ_map[{r.read_row, r.read_col}];
    end else if (r.mode == MODE_MARK || r.mode == MODE_TRACE) begin
      if (!(px < longint'(lim_x_max) && px > longint'(lim_x_min) &&
            py < longint'(lim_y_max) && py > longint'(lim_y_min))) begin
        res.ignored = 1'b1;
      end else begin
        nx = ((px < 0) ? -px : px) / c;
        ny = ((py < 0) ? -py : py) / c;
        sx = (px > 0) ? 1 : -1;
        sy = (py > 0) ? 1 : -1;
        if (r.mode == MODE_MARK) begin
          col = (px < 0) ? longint'(org_col) - nx : longint'(org_col) + 1 + nx;
          row = (py < 0) ? longint'(org_row) + 1 + ny : longint'(org_row) - ny;
          if (in_grid(col, row)) occ_map[row * GRID_COLS + col] = CELL_OCC;
          else res.off_map = 1'b1;
        end else begin
          col = (sx == 1) ? longint'(org_col) + 1 : longint'(org_col);
          row = (sy == 1) ? longint'(org_row) : longint'(org_row) + 1;
          steps = nx + ny;
          for (longint j = 0; j < steps; j++) begin
            if (!in_grid(col, row)) begin
              res.off_map = 1'b1;
              break;
            end
            if (occ_map[row * GRID_COLS + col] == CELL_UNKNOWN) begin
              occ_map[row * GRID_COLS + col] = CELL_FREE;
              if (res.cells_freed != 9'd511) res.cells_freed++;
            end else if (occ_map[row * GRID_COLS + col] == CELL_OCC) begin
              break;
            end
            jx = col + sx;
            rx = (jx - longint'(org_col) - 1) * c;
            ry = -(row - longint'(org_row)) * c;
            if (ray_crosses(rx, ry, c, px, py)) col = jx;
            else row = row - sy;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] near_coord();
    return 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Mostly well-formed points near the origin so that traces walk many cells.
  function automatic ogru_in_t make_request();
    ogru_in_t r;
    int pick;
    r = ogru_in_t'(IN_W'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 30) r.mode = MODE_MARK;
    else if (pick < 70) r.mode = MODE_TRACE;
    else if (pick < 93) r.mode = MODE_READ;
    else if (pick < 96) r.mode = MODE_NONE;
    if (pick < 90) begin
      r.point_x = near_coord();
      r.point_y = near_coord();
    end
    if (r.mode == MODE_READ && $urandom_range(0, 9) < 7) begin
      r.read_col = org_col + 8'($urandom_range(0, 24)) - 8'd12;
      r.read_row = org_row + 8'($urandom_range(0, 24)) - 8'd12;
    end
    return r;
  endfunction

  function automatic ogru_in_t directed(logic [1:0] m, logic [15:0] x, logic [15:0] y,
                                        logic [7:0] rc, logic [7:0] rr);
    ogru_in_t r;
    r.mode = m; r.point_x = x; r.point_y = y; r.read_col = rc; r.read_row = rr;
    return r;
  endfunction

  // Appends a request to the tail of the driver's queue.
  function automatic void queue_request(ogru_in_t r);
    pending_requests = {pending_requests, r};
  endfunction

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_X_MAX: lim_x_max = val;
      REG_X_MIN: lim_x_min = val;
      REG_Y_MAX: lim_y_max = val;
      REG_Y_MIN: lim_y_min = val;
      REG_CELL:  cell_mm   = val[11:0];
      REG_ORG_C: org_col   = val[7:0];
      REG_ORG_R: org_row   = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_scope(logic [15:0] xmax, logic [15:0] xmin,
                           logic [15:0] ymax, logic [15:0] ymin);
    set_reg(REG_X_MAX, xmax);
    set_reg(REG_X_MIN, xmin);
    set_reg(REG_Y_MAX, ymax);
    set_reg(REG_Y_MIN, ymin);
  endtask

  task automatic set_grid(logic [11:0] c, logic [7:0] oc, logic [7:0] orw);
    set_reg(REG_CELL, {4'd0, c});
    set_reg(REG_ORG_C, {8'd0, oc});
    set_reg(REG_ORG_R, {8'd0, orw});
  endtask

  // Request driver: inputs change on the falling edge.
  always @(posedge clk) begin
    in_fire <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      expected_results = {expected_results, update_map(in_data)};
      accepted++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap = 0;
    end else if (in_valid && !in_fire) begin
      // Request still waiting for acceptance.
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (pending_requests.size() != 0) begin
      in_data  <= pending_requests.pop_front();
      in_valid <= 1'b1;
      send_gap = pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side: random stalls, and one long hold while requests keep coming.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else if (!hold_done && accepted >= 300) begin
      hold_done = 1'b1;
      hold_off = 3000;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      recv_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    ogru_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, out_data);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.cell_state !== want.cell_state) begin
          $display("%0t: cell_state expected %0d got %0d", $time, want.cell_state,
                   out_data.cell_state);
          failures++;
        end
        if (out_data.ignored !== want.ignored) begin
          $display("%0t: ignored expected %0d got %0d", $time, want.ignored,
                   out_data.ignored);
          failures++;
        end
        if (out_data.off_map !== want.off_map) begin
          $display("%0t: off_map expected %0d got %0d", $time, want.off_map,
                   out_data.off_map);
          failures++;
        end
        if (out_data.cells_freed !== want.cells_freed) begin
          $display("%0t: cells_freed expected %0d got %0d", $time, want.cells_freed,
                   out_data.cells_freed);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    no_idle = 1'b0;
    lim_x_max = 16'sd20000; lim_x_min = -16'sd20000;
    lim_y_max = 16'sd20000; lim_y_min = -16'sd20000;
    cell_mm = 12'd200; org_col = 8'd127; org_row = 8'd127;
    span = 6000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: scope edges, axis points, far points, every mode.
    queue_request(directed(MODE_TRACE, 16'd1500, 16'd900, 8'd0, 8'd0));
    queue_request(directed(MODE_TRACE, -16'sd2300, 16'd700, 8'd0, 8'd0));
    queue_request(directed(MODE_TRACE, -16'sd900, -16'sd3100, 8'd0, 8'd0));
    queue_request(directed(MODE_TRACE, 16'd0, 16'd0, 8'd0, 8'd0));
    queue_request(directed(MODE_MARK, 16'd0, 16'd0, 8'd0, 8'd0));
    queue_request(directed(MODE_MARK, 16'd1000, 16'd0, 8'd0, 8'd0));
    queue_request(directed(MODE_TRACE, 16'd1900, 16'd0, 8'd0, 8'd0));
    queue_request(directed(MODE_TRACE, 16'd0, -16'sd1900, 8'd0, 8'd0));
    queue_request(directed(MODE_MARK, 16'd20000, 16'd0, 8'd0, 8'd0));
    queue_request(directed(MODE_MARK, 16'd19999, -16'sd19999, 8'd0, 8'd0));
    queue_request(directed(MODE_TRACE, -16'sd20000, 16'd5, 8'd0, 8'd0));
    queue_request(directed(MODE_TRACE, 16'h7FFF, 16'h8000, 8'hFF, 8'hFF));
    queue_request(directed(MODE_NONE, 16'd400, 16'd400, 8'd127, 8'd127));
    queue_request(directed(MODE_READ, 16'h8000, 16'h7FFF, 8'd132, 8'd127));
    queue_request(directed(MODE_READ, 16'd0, 16'd0, 8'd128, 8'd126));
    queue_request(directed(MODE_READ, 16'd0, 16'd0, 8'd0, 8'd0));
    queue_request(directed(MODE_READ, 16'd0, 16'd0, 8'd255, 8'd255));
    wait_drained();

    // Overflowing ray counter: one cell walks, origin in a corner.
    set_grid(12'd1, 8'd0, 8'd255);
    set_scope(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    queue_request(directed(MODE_TRACE, 16'd300, 16'd300, 8'd0, 8'd0));
    queue_request(directed(MODE_TRACE, 16'd600, 16'd100, 8'd0, 8'd0));
    queue_request(directed(MODE_TRACE, -16'sd5, 16'd5, 8'd0, 8'd0));
    queue_request(directed(MODE_MARK, 16'd255, 16'd255, 8'd0, 8'd0));
    queue_request(directed(MODE_MARK, 16'h8000, 16'h7FFF, 8'd0, 8'd0));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin set_grid(12'd200, 8'd127, 8'd127);
             set_scope(16'd20000, -16'sd20000, 16'd20000, -16'sd20000);
             span = 12000; end
        1: begin set_grid(12'd1, 8'd0, 8'd0);
             set_scope(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000); span = 150; end
        2: begin set_grid(12'd4095, 8'd255, 8'd255); span = 32767; end
        3: begin set_grid(12'd50, 8'd127, 8'd127);
             set_scope(16'd3000, -16'sd2500, 16'd2000, -16'sd3500); span = 4000; end
        4: begin set_grid(12'd100, 8'd60, 8'd200);
             set_scope(16'd9000, -16'sd6000, 16'd15000, -16'sd4000); span = 16000; end
        default: begin set_grid(12'd7, 8'd255, 8'd0);
             set_scope(16'h8000, 16'h7FFF, 16'd800, -16'sd800); span = 1000; end
      endcase
      no_idle = (p == 2);
      for (int i = 0; i < PER_PHASE; i++) queue_request(make_request());
      wait_drained();
    end

    wait_drained();
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
